// ----- src/dots_pkg.sv -----
package dots_pkg;

  localparam logic [7:0] OptPadCode    = 8'h00;
  localparam logic [7:0] OptEndCode    = 8'hFF;
  localparam logic [7:0] TargetCodeRst = 8'd53;

  typedef struct packed {
    logic       has_val;
    logic [7:0] value;
    logic       has_sum;
    logic       found;
    logic [7:0] length;
    logic       trunc;
  } dots_entry_t;

endpackage

// ----- src/dots_front.sv -----
module dots_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 target_code_we_i,
  input  logic [7:0]           target_code_i,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_area_i,
  output logic                 ent_push_o,
  output dots_pkg::dots_entry_t ent_o
);
  import dots_pkg::*;

  typedef enum logic [2:0] {
    PhCode,
    PhLenSkip,
    PhLenMatch,
    PhSkip,
    PhEmit,
    PhDone
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  target_q;
  logic [7:0]  rem_q, rem_d;
  logic        seen_q, seen_d;
  logic [7:0]  mlen_q, mlen_d;
  logic [7:0]  rem_dec;
  logic        emit;
  logic        trunc;

  assign rem_dec = rem_q - 8'd1;

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    seen_d  = seen_q;
    mlen_d  = mlen_q;
    emit    = 1'b0;
    case (phase_q)
      PhCode: begin
        if (data_byte_i == OptEndCode) begin
          phase_d = PhDone;
        end else if (data_byte_i == OptPadCode) begin
          phase_d = PhCode;
        end else if (data_byte_i == target_q) begin
          seen_d  = 1'b1;
          phase_d = PhLenMatch;
        end else begin
          phase_d = PhLenSkip;
        end
      end
      PhLenSkip: begin
        rem_d   = data_byte_i;
        phase_d = (data_byte_i == 8'd0) ? PhCode : PhSkip;
      end
      PhLenMatch: begin
        mlen_d  = data_byte_i;
        rem_d   = data_byte_i;
        phase_d = (data_byte_i == 8'd0) ? PhDone : PhEmit;
      end
      PhSkip: begin
        rem_d = rem_dec;
        if (rem_dec == 8'd0) begin
          phase_d = PhCode;
        end
      end
      PhEmit: begin
        emit  = 1'b1;
        rem_d = rem_dec;
        if (rem_dec == 8'd0) begin
          phase_d = PhDone;
        end
      end
      default: begin
      end
    endcase
  end

  assign trunc = (phase_d == PhLenSkip) || (phase_d == PhLenMatch) ||
                 (phase_d == PhSkip) || (phase_d == PhEmit);

  always_comb begin
    ent_o.has_val = emit;
    ent_o.value   = data_byte_i;
    ent_o.has_sum = end_of_area_i;
    ent_o.found   = seen_d;
    ent_o.length  = seen_d ? mlen_d : 8'd0;
    ent_o.trunc   = trunc;
  end

  assign ent_push_o = accept_i && (emit || end_of_area_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhCode;
      rem_q    <= 8'd0;
      seen_q   <= 1'b0;
      mlen_q   <= 8'd0;
      target_q <= TargetCodeRst;
    end else begin
      if (target_code_we_i) begin
        target_q <= target_code_i;
      end
      if (accept_i) begin
        if (end_of_area_i) begin
          phase_q <= PhCode;
          rem_q   <= 8'd0;
          seen_q  <= 1'b0;
          mlen_q  <= 8'd0;
        end else begin
          phase_q <= phase_d;
          rem_q   <= rem_d;
          seen_q  <= seen_d;
          mlen_q  <= mlen_d;
        end
      end
    end
  end

endmodule

// ----- src/dots_queue.sv -----
module dots_queue #(
  parameter int Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dots_pkg::dots_entry_t wdata_i,
  input  logic                 pop_i,
  output dots_pkg::dots_entry_t rdata_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import dots_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dots_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/dots_back.sv -----
module dots_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  dots_pkg::dots_entry_t q_data_i,
  output logic                 q_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic                 result_kind_o,
  output logic [7:0]           value_byte_o,
  output logic                 option_found_o,
  output logic [7:0]           option_length_o,
  output logic                 truncated_o,
  output logic                 run_last_o
);
  import dots_pkg::*;

  dots_entry_t ent_q;
  logic        ent_valid_q;
  logic        take, last_part, load;

  assign empty_o   = !ent_valid_q;
  assign take      = pop_i && ent_valid_q;
  // value part followed by a summary keeps the entry for one more item
  assign last_part = !(ent_q.has_val && ent_q.has_sum);
  assign load      = !ent_valid_q || (take && last_part);
  assign q_pop_o   = load && !q_empty_i;

  always_comb begin
    if (ent_q.has_val) begin
      result_kind_o   = 1'b0;
      value_byte_o    = ent_q.value;
      option_found_o  = 1'b0;
      option_length_o = 8'd0;
      truncated_o     = 1'b0;
      run_last_o      = !ent_q.has_sum;
    end else begin
      result_kind_o   = 1'b1;
      value_byte_o    = 8'd0;
      option_found_o  = ent_q.found;
      option_length_o = ent_q.length;
      truncated_o     = ent_q.trunc;
      run_last_o      = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= q_data_i;
    end else if (take) begin
      ent_q.has_val <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (load) begin
      ent_valid_q <= !q_empty_i;
    end
  end

endmodule

// ----- src/dhcp_option_tlv_scanner_top.sv -----
// Channel  Handshake             Payload
// in       push / full           data_byte_i, end_of_area_i
// result   empty / pop           result_kind_o, value_byte_o, option_found_o,
//                                option_length_o, truncated_o, run_last_o
// config   target_code_we_i      target_code_i
//
// One byte per cycle is taken while full is low; the scan state updates in that cycle.
// A byte yields zero, one or two result items; a two-item byte holds the output
// stage for two pops. Results pass through the queue and then the output register.
// full rises when the QueueDepth-entry queue between scanner and output is full.
// Reset (rst_ni low) clears the scan state, the queue and the output stage.
module dhcp_option_tlv_scanner_top #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       target_code_we_i,
  input  logic [7:0] target_code_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_area_i,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind_o,
  output logic [7:0] value_byte_o,
  output logic       option_found_o,
  output logic [7:0] option_length_o,
  output logic       truncated_o,
  output logic       run_last_o
);
  import dots_pkg::*;

  dots_entry_t ent_w, head_w;
  logic        accept, ent_push, q_pop, q_empty;

  assign accept = push && !full;

  dots_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .target_code_we_i (target_code_we_i),
    .target_code_i    (target_code_i),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .end_of_area_i    (end_of_area_i),
    .ent_push_o       (ent_push),
    .ent_o            (ent_w)
  );

  dots_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ent_push),
    .wdata_i (ent_w),
    .pop_i   (q_pop),
    .rdata_o (head_w),
    .full_o  (full),
    .empty_o (q_empty)
  );

  dots_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (head_w),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .result_kind_o   (result_kind_o),
    .value_byte_o    (value_byte_o),
    .option_found_o  (option_found_o),
    .option_length_o (option_length_o),
    .truncated_o     (truncated_o),
    .run_last_o      (run_last_o)
  );

endmodule

// ----- sim/dhcp_option_tlv_scanner_top_tb.sv -----
`timescale 1ns / 1ps

module dhcp_option_tlv_scanner_top_tb;
  import dots_pkg::*;

  typedef enum logic [2:0] {
    ScanCode,
    ScanLenSkip,
    ScanLenMatch,
    ScanSkip,
    ScanEmit,
    ScanDone
  } scan_phase_e;

  localparam logic ResValue   = 1'b0;
  localparam logic ResSummary = 1'b1;

  typedef struct {
    logic       kind;
    logic [7:0] value;
    logic       found;
    logic [7:0] length;
    logic       trunc;
    logic       last;
  } option_result_t;

  class option_scan_predictor;
    logic [7:0]     target;
    scan_phase_e    phase;
    logic [7:0]     remaining;
    logic           match_seen;
    logic [7:0]     match_len;
    option_result_t expected_results[$];
    int             errors;

    function new();
      target = TargetCodeRst;
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      phase      = ScanCode;
      remaining  = 8'd0;
      match_seen = 1'b0;
      match_len  = 8'd0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // accepted input byte
    function void take_byte(logic [7:0] b, logic last);
      option_result_t r;
      logic           emit;
      emit = 1'b0;
      case (phase)
        ScanCode: begin
          if (b == OptEndCode) phase = ScanDone;
          else if (b == OptPadCode) phase = ScanCode;
          else if (b == target) begin
            match_seen = 1'b1;
            phase = ScanLenMatch;
          end else phase = ScanLenSkip;
        end
        ScanLenSkip: begin
          remaining = b;
          phase = (b == 8'd0) ? ScanCode : ScanSkip;
        end
        ScanLenMatch: begin
          match_len = b;
          remaining = b;
          phase = (b == 8'd0) ? ScanDone : ScanEmit;
        end
        ScanSkip: begin
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) phase = ScanCode;
        end
        ScanEmit: begin
          emit = 1'b1;
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) phase = ScanDone;
        end
        default: ;
      endcase

      if (emit) begin
        r.kind   = ResValue;
        r.value  = b;
        r.found  = 1'b0;
        r.length = 8'd0;
        r.trunc  = 1'b0;
        r.last   = !last;
        expected_results.push_back(r);
      end
      if (last) begin
        r.kind   = ResSummary;
        r.value  = 8'd0;
        r.found  = match_seen;
        r.length = match_seen ? match_len : 8'd0;
        r.trunc  = phase inside {ScanLenSkip, ScanLenMatch, ScanSkip, ScanEmit};
        r.last   = 1'b1;
        expected_results.push_back(r);
        clear_scan();
      end
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(option_result_t got);
      option_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("unexpected result item: kind %0d value %0d", got.kind, got.value);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      check_field("result_kind", exp_r.kind, got.kind);
      check_field("value_byte", exp_r.value, got.value);
      check_field("option_found", exp_r.found, got.found);
      check_field("option_length", exp_r.length, got.length);
      check_field("truncated", exp_r.trunc, got.trunc);
      check_field("run_last", exp_r.last, got.last);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       target_code_we = 1'b0;
  logic [7:0] target_code = 8'd0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'd0;
  logic       end_of_area = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       result_kind;
  logic [7:0] value_byte;
  logic       option_found;
  logic [7:0] option_length;
  logic       truncated;
  logic       run_last;

  option_scan_predictor scan_model;
  logic [7:0] area_q[$];
  int         bytes_sent = 0;
  int         holds_asked = 0;
  bit         no_idle = 1'b0;

  dhcp_option_tlv_scanner_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .target_code_we_i (target_code_we),
    .target_code_i    (target_code),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte),
    .end_of_area_i    (end_of_area),
    .empty            (empty),
    .pop              (pop),
    .result_kind_o    (result_kind),
    .value_byte_o     (value_byte),
    .option_found_o   (option_found),
    .option_length_o  (option_length),
    .truncated_o      (truncated),
    .run_last_o       (run_last)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #400us;
    $display("CHECKS FAILED");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    data_byte   <= b;
    end_of_area <= last;
    do @(posedge clk_i); while (full);
    scan_model.take_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_area();
    int i;
    for (i = 0; i < area_q.size(); i++) send_byte(area_q[i], i == area_q.size() - 1);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (scan_model.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_target(input logic [7:0] code);
    target_code_we <= 1'b1;
    target_code    <= code;
    @(posedge clk_i);
    scan_model.target = code;
    @(negedge clk_i);
    target_code_we <= 1'b0;
  endtask

  task automatic build_random_area(input logic [7:0] tgt);
    int         r;
    int         len;
    int         k;
    logic [7:0] code;
    area_q.delete();
    if ($urandom_range(0, 99) < 75) begin
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 99) < 15) begin
          area_q.push_back(OptPadCode);
        end else begin
          code = ($urandom_range(0, 99) < 30) ? tgt : 8'($urandom_range(1, 254));
          r = $urandom_range(0, 99);
          if (r < 80) len = $urandom_range(0, 6);
          else if (r < 99) len = $urandom_range(7, 24);
          else len = $urandom_range(25, 60);
          area_q.push_back(code);
          area_q.push_back(8'(len));
          repeat (len) area_q.push_back(8'($urandom));
        end
      end
      if ($urandom_range(0, 99) < 70) begin
        area_q.push_back(OptEndCode);
        repeat ($urandom_range(0, 3)) area_q.push_back(8'($urandom));
      end
      // cut the area short somewhere
      if (area_q.size() > 1 && $urandom_range(0, 99) < 15) begin
        k = $urandom_range(1, area_q.size() - 1);
        while (area_q.size() > k) void'(area_q.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 12)) area_q.push_back(8'($urandom));
    end
    if (area_q.size() == 0) area_q.push_back(8'($urandom));
  endtask

  // result side
  initial begin
    option_result_t got;
    int             holds_served;
    int             n;
    holds_served = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        pop <= 1'b0;
        for (n = 0; n < 150; n++) @(negedge clk_i);
      end
      pop <= no_idle || ($urandom_range(0, 99) >= 15);
      @(posedge clk_i);
      if (pop && !empty) begin
        got.kind   = result_kind;
        got.value  = value_byte;
        got.found  = option_found;
        got.length = option_length;
        got.trunc  = truncated;
        got.last   = run_last;
        scan_model.check_result(got);
      end
    end
  end

  initial begin
    logic [7:0] tgt;
    int         ph;
    int         start_count;
    scan_model = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed areas, reset target
    area_q = '{OptPadCode, OptEndCode};
    send_area();
    area_q = '{TargetCodeRst, 8'd2, 8'hAA, 8'h55};
    send_area();
    area_q = '{TargetCodeRst, 8'd0, 8'd7};
    send_area();
    area_q = '{8'd12, 8'd0, 8'd9, 8'd1, 8'hFF, TargetCodeRst};
    send_area();
    area_q = '{TargetCodeRst, 8'd3, 8'h01};
    send_area();
    area_q = '{OptEndCode};
    send_area();
    area_q = '{OptPadCode};
    send_area();
    area_q = '{8'd200, 8'd5, 8'h80};
    send_area();

    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: tgt = 8'd1;
        1: tgt = 8'd254;
        2: tgt = OptPadCode;
        3: tgt = OptEndCode;
        default: tgt = 8'($urandom_range(1, 254));
      endcase
      write_target(tgt);
      no_idle = (ph == 1);
      start_count = bytes_sent;
      while (bytes_sent - start_count < 65) begin
        build_random_area(tgt);
        send_area();
      end
      if (ph == 4) begin
        // long matched record while the result side holds off
        wait_idle();
        area_q.delete();
        area_q.push_back(tgt);
        area_q.push_back(8'd255);
        repeat (255) area_q.push_back(8'($urandom));
        area_q.push_back(OptEndCode);
        holds_asked++;
        send_area();
      end
    end

    push <= 1'b0;
    while (scan_model.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (scan_model.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dots_pkg.sv
src/dots_front.sv
src/dots_queue.sv
src/dots_back.sv
src/dhcp_option_tlv_scanner_top.sv
sim/dhcp_option_tlv_scanner_top_tb.sv
